### hw/rtl/vdfs_pkg.sv
// ----------------------------------------------------------------------------
// vdfs_pkg: shared definitions of the variable duration frame sequencer
// field widths, item codes, controller states and the command and status
// bundles between controller and datapath
// ----------------------------------------------------------------------------
package vdfs_pkg;

    localparam int MAX_FRAMES_DEF = 16;

    localparam int DUR_W     = 24;
    localparam int ELAPSED_W = 24;
    localparam int ACC_W     = 25;
    localparam int IDX_W     = 4;
    localparam int FRAME_W   = 4;
    localparam int CNT_W     = 5;
    localparam int MOD_CNT_W = $clog2(ACC_W);

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_RD,
        ST_CMP,
        ST_CHK,
        ST_MOD,
        ST_FIN
    } vdfs_state_t;

    typedef struct packed {
        logic req_ready;
        logic start_write;
        logic start_tick;
        logic sum_rd;
        logic sum_done;
        logic step_cmp;
        logic mod_start;
        logic mod_step;
        logic load_out;
    } vdfs_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic req_write;
        logic need_sum;
        logic sum_all_issued;
        logic sum_pending;
        logic step_go;
        logic step_last;
        logic total_zero;
        logic acc_ge_total;
        logic mod_last;
        logic out_free;
    } vdfs_sts_t;

endpackage

### hw/rtl/vdfs_req_if.sv
// ----------------------------------------------------------------------------
// vdfs_req_if: request channel of the frame sequencer
// carries tick and table write requests with a valid/ready handshake
// ----------------------------------------------------------------------------
interface vdfs_req_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [vdfs_pkg::ELAPSED_W-1:0] elapsed_us;
    logic [vdfs_pkg::IDX_W-1:0]     entry_index;
    logic [vdfs_pkg::DUR_W-1:0]     entry_duration;

    modport source (
        output valid, kind, elapsed_us, entry_index, entry_duration,
        input  ready
    );

    modport sink (
        input  valid, kind, elapsed_us, entry_index, entry_duration,
        output ready
    );
endinterface

### hw/rtl/vdfs_rsp_if.sv
// ----------------------------------------------------------------------------
// vdfs_rsp_if: response channel of the frame sequencer
// carries the frame index and the advance and wrap flags of one request
// ----------------------------------------------------------------------------
interface vdfs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [vdfs_pkg::FRAME_W-1:0] current_frame;
    logic                         advanced;
    logic                         wrapped;

    modport source (
        output valid, current_frame, advanced, wrapped,
        input  ready
    );

    modport sink (
        input  valid, current_frame, advanced, wrapped,
        output ready
    );
endinterface

### hw/rtl/vdfs_cfg_if.sv
// ----------------------------------------------------------------------------
// vdfs_cfg_if: configuration write channel of the frame sequencer
// carries the number of frames in use
// ----------------------------------------------------------------------------
interface vdfs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [vdfs_pkg::CNT_W-1:0] frame_count;

    modport source (
        output valid, frame_count,
        input  ready
    );

    modport sink (
        input  valid, frame_count,
        output ready
    );
endinterface

### hw/rtl/vdfs_ram.sv
// ----------------------------------------------------------------------------
// vdfs_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module vdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/vdfs_datapath.sv
// ----------------------------------------------------------------------------
// vdfs_datapath: frame sequencer datapath
// duration table, accumulator, frame index, cached table total,
// bit-serial remainder unit and the response register
// ----------------------------------------------------------------------------
module vdfs_datapath #(
    parameter int MAX_FRAMES = vdfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    vdfs_req_if.sink            req,
    vdfs_rsp_if.source          rsp,
    vdfs_cfg_if.sink            cfg,
    input  vdfs_pkg::vdfs_cmd_t cmd,
    output vdfs_pkg::vdfs_sts_t sts
);

    localparam int DUR_W   = vdfs_pkg::DUR_W;
    localparam int ACC_W   = vdfs_pkg::ACC_W;
    localparam int IDX_W   = vdfs_pkg::IDX_W;
    localparam int FRAME_W = vdfs_pkg::FRAME_W;
    localparam int CNT_W   = vdfs_pkg::CNT_W;
    localparam int MC_W    = vdfs_pkg::MOD_CNT_W;
    localparam int POS_W   = $clog2(MAX_FRAMES);
    localparam int N_W     = $clog2(MAX_FRAMES + 1);
    localparam int TOTAL_W = DUR_W + POS_W;
    localparam int NC_W    = (N_W > CNT_W) ? N_W : CNT_W;
    localparam int IC_W    = (N_W > IDX_W) ? N_W : IDX_W;
    localparam int PF_W    = POS_W + FRAME_W;
    localparam int PI_W    = POS_W + IDX_W;

    // control state
    logic [CNT_W-1:0]   frame_count_reg, frame_count_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               adv_reg, adv_next;
    logic               wrap_reg, wrap_next;
    logic               total_ok_reg, total_ok_next;
    logic               sum_pend_reg, sum_pend_next;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [N_W-1:0]     total_n_reg, total_n_next;
    logic [N_W-1:0]     sum_cnt_reg, sum_cnt_next;
    logic [TOTAL_W-1:0] mod_r_reg, mod_r_next;
    logic [MC_W-1:0]    mod_cnt_reg, mod_cnt_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;
    logic               out_adv_reg, out_adv_next;
    logic               out_wrap_reg, out_wrap_next;

    logic [NC_W-1:0]    fc_ext;
    logic [N_W-1:0]     n_c;
    logic [IC_W-1:0]    idx_ext;
    logic [PI_W-1:0]    idx_wide;
    logic [PF_W-1:0]    pos_wide;
    logic               wr_ok;
    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [DUR_W-1:0]   ram_wdata;
    logic [POS_W-1:0]   ram_raddr;
    logic [DUR_W-1:0]   ram_rdata;
    logic               sum_issue;
    logic               pos_ge_n;
    logic [TOTAL_W:0]   mod_t;
    logic [TOTAL_W:0]   mod_diff;
    logic [TOTAL_W-1:0] mod_r_step;

    vdfs_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // frames in use: zero counts as one, large values saturate
    always_comb
    begin
        fc_ext = NC_W'(frame_count_reg);
        if (fc_ext == '0)
        begin
            n_c = N_W'(1);
        end
        else if (fc_ext > NC_W'(MAX_FRAMES))
        begin
            n_c = N_W'(MAX_FRAMES);
        end
        else
        begin
            n_c = N_W'(fc_ext);
        end
    end

    // table write port
    assign idx_ext   = IC_W'(req.entry_index);
    assign idx_wide  = PI_W'(req.entry_index);
    assign wr_ok     = idx_ext < IC_W'(MAX_FRAMES);
    assign ram_we    = cmd.start_write && wr_ok;
    assign ram_waddr = idx_wide[POS_W-1:0];
    assign ram_wdata = (req.entry_duration == '0) ? DUR_W'(1) : req.entry_duration;

    assign sum_issue = cmd.sum_rd && (sum_cnt_reg < n_c);
    assign ram_raddr = cmd.sum_rd ? sum_cnt_reg[POS_W-1:0] : pos_reg;

    assign pos_ge_n  = N_W'(pos_reg) >= n_c;
    assign pos_wide  = PF_W'(pos_reg);

    // one remainder bit per cycle
    assign mod_t      = {mod_r_reg, accum_reg[ACC_W-1]};
    assign mod_diff   = mod_t - (TOTAL_W + 1)'(total_reg);
    assign mod_r_step = (mod_t >= (TOTAL_W + 1)'(total_reg)) ? mod_diff[TOTAL_W-1:0]
                                                              : mod_t[TOTAL_W-1:0];

    // status toward the controller
    always_comb
    begin
        sts                = '0;
        sts.req_valid      = req.valid;
        sts.req_write      = (req.kind == vdfs_pkg::KIND_WRITE);
        sts.need_sum       = !total_ok_reg || (total_n_reg != n_c);
        sts.sum_all_issued = (sum_cnt_reg == n_c);
        sts.sum_pending    = sum_pend_reg;
        sts.step_go        = accum_reg >= ACC_W'(ram_rdata);
        sts.step_last      = (N_W'(pos_reg) + N_W'(1)) == n_c;
        sts.total_zero     = (total_reg == '0);
        sts.acc_ge_total   = TOTAL_W'(accum_reg) >= total_reg;
        sts.mod_last       = (mod_cnt_reg == MC_W'(ACC_W - 1));
        sts.out_free       = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        frame_count_next = frame_count_reg;
        accum_next       = accum_reg;
        pos_next         = pos_reg;
        adv_next         = adv_reg;
        wrap_next        = wrap_reg;
        total_ok_next    = total_ok_reg;
        sum_pend_next    = sum_issue;
        out_valid_next   = out_valid_reg;
        total_next       = total_reg;
        total_n_next     = total_n_reg;
        sum_cnt_next     = sum_cnt_reg;
        mod_r_next       = mod_r_reg;
        mod_cnt_next     = mod_cnt_reg;
        out_frame_next   = out_frame_reg;
        out_adv_next     = out_adv_reg;
        out_wrap_next    = out_wrap_reg;

        if (cfg.valid)
        begin
            frame_count_next = cfg.frame_count;
        end

        if (cmd.start_write)
        begin
            total_ok_next = 1'b0;
            adv_next      = 1'b0;
            wrap_next     = 1'b0;
        end

        if (cmd.start_tick)
        begin
            adv_next   = 1'b0;
            wrap_next  = 1'b0;
            accum_next = ACC_W'(accum_reg + ACC_W'(req.elapsed_us));
            if (pos_ge_n)
            begin
                pos_next = '0;
            end
            if (sts.need_sum)
            begin
                total_next   = '0;
                sum_cnt_next = '0;
            end
        end

        // table total, one entry a cycle
        if (sum_issue)
        begin
            sum_cnt_next = sum_cnt_reg + N_W'(1);
        end
        if (sum_pend_reg)
        begin
            total_next = total_reg + TOTAL_W'(ram_rdata);
        end
        if (cmd.sum_done)
        begin
            total_ok_next = 1'b1;
            total_n_next  = n_c;
        end

        if (cmd.step_cmp && sts.step_go)
        begin
            accum_next = accum_reg - ACC_W'(ram_rdata);
            adv_next   = 1'b1;
            if (sts.step_last)
            begin
                pos_next  = '0;
                wrap_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        if (cmd.mod_start)
        begin
            mod_r_next   = '0;
            mod_cnt_next = '0;
        end

        // accumulator shifts out its bits msb first, then takes the remainder
        if (cmd.mod_step)
        begin
            mod_r_next   = mod_r_step;
            mod_cnt_next = mod_cnt_reg + MC_W'(1);
            if (sts.mod_last)
            begin
                accum_next = mod_r_step[ACC_W-1:0];
            end
            else
            begin
                accum_next = {accum_reg[ACC_W-2:0], 1'b0};
            end
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_frame_next = pos_wide[FRAME_W-1:0];
            out_adv_next   = adv_reg;
            out_wrap_next  = wrap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= vdfs_pkg::FRAME_COUNT_RST;
            accum_reg       <= '0;
            pos_reg         <= '0;
            adv_reg         <= 1'b0;
            wrap_reg        <= 1'b0;
            total_ok_reg    <= 1'b0;
            sum_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            accum_reg       <= accum_next;
            pos_reg         <= pos_next;
            adv_reg         <= adv_next;
            wrap_reg        <= wrap_next;
            total_ok_reg    <= total_ok_next;
            sum_pend_reg    <= sum_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        total_n_reg   <= total_n_next;
        sum_cnt_reg   <= sum_cnt_next;
        mod_r_reg     <= mod_r_next;
        mod_cnt_reg   <= mod_cnt_next;
        out_frame_reg <= out_frame_next;
        out_adv_reg   <= out_adv_next;
        out_wrap_reg  <= out_wrap_next;
    end

    assign req.ready         = cmd.req_ready;
    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.current_frame = out_frame_reg;
    assign rsp.advanced      = out_adv_reg;
    assign rsp.wrapped       = out_wrap_reg;

endmodule

### hw/rtl/vdfs_ctrl.sv
// ----------------------------------------------------------------------------
// vdfs_ctrl: frame sequencer controller
// sequences table summing, compare-subtract steps, remainder and response
// ----------------------------------------------------------------------------
module vdfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  vdfs_pkg::vdfs_sts_t sts,
    output vdfs_pkg::vdfs_cmd_t cmd
);

    vdfs_pkg::vdfs_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vdfs_pkg::ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    if (sts.req_write)
                    begin
                        state_next = vdfs_pkg::ST_FIN;
                    end
                    else if (sts.need_sum)
                    begin
                        state_next = vdfs_pkg::ST_SUM;
                    end
                    else
                    begin
                        state_next = vdfs_pkg::ST_RD;
                    end
                end
            end
            vdfs_pkg::ST_SUM:
            begin
                if (sts.sum_all_issued && !sts.sum_pending)
                begin
                    state_next = vdfs_pkg::ST_RD;
                end
            end
            vdfs_pkg::ST_RD:
            begin
                state_next = vdfs_pkg::ST_CMP;
            end
            vdfs_pkg::ST_CMP:
            begin
                if (!sts.step_go)
                begin
                    state_next = vdfs_pkg::ST_FIN;
                end
                else if (sts.step_last)
                begin
                    state_next = vdfs_pkg::ST_CHK;
                end
                else
                begin
                    state_next = vdfs_pkg::ST_RD;
                end
            end
            vdfs_pkg::ST_CHK:
            begin
                // empty table total cannot make progress
                if (sts.total_zero)
                begin
                    state_next = vdfs_pkg::ST_FIN;
                end
                else if (sts.acc_ge_total)
                begin
                    state_next = vdfs_pkg::ST_MOD;
                end
                else
                begin
                    state_next = vdfs_pkg::ST_RD;
                end
            end
            vdfs_pkg::ST_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = vdfs_pkg::ST_RD;
                end
            end
            vdfs_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = vdfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vdfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            vdfs_pkg::ST_IDLE:
            begin
                cmd.req_ready   = 1'b1;
                cmd.start_write = sts.req_valid && sts.req_write;
                cmd.start_tick  = sts.req_valid && !sts.req_write;
            end
            vdfs_pkg::ST_SUM:
            begin
                cmd.sum_rd   = 1'b1;
                cmd.sum_done = sts.sum_all_issued && !sts.sum_pending;
            end
            vdfs_pkg::ST_RD:
            begin
                cmd = '0;
            end
            vdfs_pkg::ST_CMP:
            begin
                cmd.step_cmp = 1'b1;
            end
            vdfs_pkg::ST_CHK:
            begin
                cmd.mod_start = !sts.total_zero && sts.acc_ge_total;
            end
            vdfs_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            vdfs_pkg::ST_FIN:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/variable_duration_frame_sequencer.sv
// ----------------------------------------------------------------------------
// variable_duration_frame_sequencer: steps through a table of frame durations
// write request: response loaded in the finish state, then back to idle
// tick: each frame advance adds a table ram read then a compare-subtract,
// each wrap adds a check state, a remainder pass runs when a whole table
// cycle still fits, and the table is re-summed after a table write or a
// frame count change
// reset: accumulator, frame index and frame count (1) cleared, table contents
// undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module variable_duration_frame_sequencer #(
    parameter int MAX_FRAMES = vdfs_pkg::MAX_FRAMES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vdfs_req_if.sink   req,
    vdfs_rsp_if.source rsp,
    vdfs_cfg_if.sink   cfg
);

    vdfs_pkg::vdfs_cmd_t cmd;
    vdfs_pkg::vdfs_sts_t sts;

    vdfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    vdfs_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
